[rtl/fbs_pkg.sv]
// Shared types, constants and geometry helpers of the falling box stack.
package fbs_pkg;

	localparam int MAX_BOXES_DEF = 16;

	// Register indexes of the configuration channel
	localparam logic [2:0] REG_FLOOR_Y     = 3'd0;
	localparam logic [2:0] REG_BOX_SIZE    = 3'd1;
	localparam logic [2:0] REG_ACCEL_START = 3'd2;
	localparam logic [2:0] REG_ACCEL_STEP  = 3'd3;
	localparam logic [2:0] REG_ACCEL_CAP   = 3'd4;
	localparam logic [2:0] REG_GAIN        = 3'd5;

	// Result status codes
	localparam logic [2:0] ST_POS     = 3'd0;
	localparam logic [2:0] ST_SPAWNED = 3'd1;
	localparam logic [2:0] ST_BLOCKED = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	// floor(p / 100) = (p * 5243) >> 19 for every p up to 7 * 255
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int          DIV100_SH  = 19;

	typedef struct packed {
		logic signed [10:0] left;
		logic signed [10:0] top;
		logic [7:0]         accel;
	} box_t;

	function automatic logic overlaps(input logic signed [10:0] ax, input logic signed [10:0] ay,
		input logic signed [10:0] bx, input logic signed [10:0] by, input logic [7:0] s);
		logic signed [11:0] dx;
		logic signed [11:0] dy;
		logic [11:0]        adx;
		logic [11:0]        ady;
		dx  = 12'(ax) - 12'(bx);
		dy  = 12'(ay) - 12'(by);
		adx = dx[11] ? 12'(-dx) : 12'(dx);
		ady = dy[11] ? 12'(-dy) : 12'(dy);
		return (adx <= {4'b0, s}) && (ady <= {4'b0, s});
	endfunction

	// b lies below a; with a zero size every overlap counts as below
	function automatic logic below(input logic signed [10:0] ax, input logic signed [10:0] ay,
		input logic signed [10:0] bx, input logic signed [10:0] by, input logic [7:0] s);
		logic signed [11:0] dx;
		logic signed [11:0] dy;
		dx = 12'(ax) - 12'(bx);
		dy = 12'(ay) - 12'(by);
		return overlaps(ax, ay, bx, by, s) &&
			((s == 8'd0) || ((dy <= dx) && (dy <= -dx)));
	endfunction

endpackage

[rtl/fbs_cell.sv]
// One cell of the box ring: holds one box and passes it on when the ring turns.
module fbs_cell
	import fbs_pkg::*;
(
	input  logic clk,
	input  logic shift,
	input  box_t d,
	output box_t q
);

	box_t box_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			box_q <= d;
		end
	end

	assign q = box_q;

endmodule

[rtl/falling_box_stack_step.sv]
// Top level of the falling box stack: box ring, sequencer and stream ports.
//
//  channel   | ports                                  | payload
//  ----------+----------------------------------------+-------------------------------
//  input     | s_axis_tvalid/tready/tdata/tuser       | tuser kind, tdata cursor x, y
//  output    | m_axis_tvalid/tready/tdata/tuser/tlast | tuser status, tdata slot, x, y
//  config    | cfg_valid/cfg_ready/cfg_index/cfg_data | register index, write data
//
// The boxes sit in a ring of MAX_BOXES cells that, when it turns, moves one place per cycle past
// the compare logic at the head. A spawn turns the ring through one full turn and then on to the
// free slot; a tick turns it a full turn and one place more for every stored box, then aligns it
// and reports each box. One item is worked on at a time.
// Reset clears the box count and the sequencer; ring contents are left as they are.
// A stalled output holds the ring still while positions are reported; configuration transfers are always taken.
module falling_box_stack_step
	import fbs_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [9:0] cursor_x, [19:10] cursor_y, rest zero
	input  logic        s_axis_tuser,  // [0] kind: 0 tick, 1 spawn
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [5:0] slot, [16:6] box_x, [27:17] box_y, rest zero
	output logic [2:0]  m_axis_tuser,  // [2:0] status
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int SW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_BOXES - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_BOXES);

	typedef enum logic [3:0] {
		IDLE, SP_SCAN, SP_WRITE, EMIT, ALIGN, TK_CAPT, TK_SCAN, MUL1, MUL2, UPD, REPORT
	} state_t;

	// configuration registers
	logic [9:0] floor_y_q;
	logic [7:0] box_size_q;
	logic [7:0] accel_start_q;
	logic [5:0] accel_step_q;
	logic [7:0] accel_cap_q;
	logic [2:0] gain_q;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [SW-1:0]  head_slot_q;
	logic [SW-1:0]  turn_q;
	logic [SW-1:0]  box_idx_q;
	logic           rep_q;
	logic           hit_q;
	logic [SW-1:0]  hit_slot_q;
	logic           stop_q;
	box_t           probe_q;
	logic [7:0]     accel_new_q;
	logic [10:0]    prod_q;
	logic [4:0]     drop_q;
	logic [2:0]     res_status_q;
	logic [5:0]     res_slot_q;

	logic           out_valid_q;
	logic [2:0]     out_status_q;
	logic [5:0]     out_slot_q;
	logic [10:0]    out_x_q;
	logic [10:0]    out_y_q;
	logic           out_last_q;

	box_t cell_d [MAX_BOXES];
	box_t cell_q [MAX_BOXES];
	box_t head;
	box_t tail_d;
	logic rotate;

	logic               in_xfer;
	logic               out_free;
	logic               emit_now;
	logic               head_live;
	logic               head_hit;
	logic               hit_now;
	logic [SW-1:0]      hit_slot_now;
	logic [SW-1:0]      head_next;
	logic [6:0]         half;
	logic signed [10:0] spawn_x;
	logic signed [10:0] spawn_y;
	logic [8:0]         accel_sum;
	logic [7:0]         accel_grow;
	logic signed [11:0] top_sum;
	logic signed [10:0] top_new;
	logic [23:0]        quot_full;
	box_t               spawn_box;
	box_t               upd_box;

	// ring of cells; the tail takes the head back or a replacement box
	for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
		if (k == MAX_BOXES - 1) begin : g_tail
			assign cell_d[k] = tail_d;
		end else begin : g_link
			assign cell_d[k] = cell_q[k+1];
		end
		fbs_cell u_cell (
			.clk   (clk),
			.shift (rotate),
			.d     (cell_d[k]),
			.q     (cell_q[k])
		);
	end

	assign head      = cell_q[0];
	assign head_next = (head_slot_q == LAST_SLOT) ? '0 : head_slot_q + 1'b1;
	assign head_live = CW'(head_slot_q) < count_q;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	// load the output register from the emit and report states
	assign emit_now      = out_free && ((state_q == EMIT) || (state_q == REPORT));

	assign half    = box_size_q[7:1];
	assign spawn_x = $signed({1'b0, s_axis_tdata[9:0]}) - $signed({4'b0, half});
	assign spawn_y = $signed({1'b0, s_axis_tdata[19:10]}) - $signed({4'b0, half});

	// lowest stored slot in the way of the spawn candidate
	assign head_hit     = head_live &&
		overlaps(head.left, head.top, probe_q.left, probe_q.top, box_size_q);
	assign hit_now      = hit_q || head_hit;
	assign hit_slot_now = (head_hit && (!hit_q || head_slot_q < hit_slot_q)) ?
		head_slot_q : hit_slot_q;

	assign accel_sum  = {1'b0, head.accel} + {3'b0, accel_step_q};
	assign accel_grow = accel_sum[8] ? 8'hFF : accel_sum[7:0];

	assign quot_full = 24'(prod_q) * 24'(DIV100_MUL);
	assign top_sum   = 12'(probe_q.top) + $signed({7'b0, drop_q});
	assign top_new   = (top_sum > 12'sd1023) ? 11'sd1023 : top_sum[10:0];

	assign spawn_box = '{left: probe_q.left, top: probe_q.top, accel: accel_start_q};
	assign upd_box   = stop_q ? probe_q :
		'{left: probe_q.left, top: top_new, accel: accel_new_q};

	always_comb begin
		rotate = 1'b0;
		tail_d = head;
		case (state_q)
			SP_SCAN, TK_CAPT, TK_SCAN: rotate = 1'b1;
			SP_WRITE: begin
				rotate = 1'b1;
				if (CW'(head_slot_q) == count_q) begin
					tail_d = spawn_box;
				end
			end
			UPD: begin
				rotate = 1'b1;
				tail_d = upd_box;
			end
			ALIGN:  rotate = (head_slot_q != '0);
			REPORT: rotate = out_free;
			default: rotate = 1'b0;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_y_q     <= 10'd500;
			box_size_q    <= 8'd100;
			accel_start_q <= 8'd10;
			accel_step_q  <= 6'd4;
			accel_cap_q   <= 8'd200;
			gain_q        <= 3'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FLOOR_Y:     floor_y_q     <= cfg_data;
				REG_BOX_SIZE:    box_size_q    <= cfg_data[7:0];
				REG_ACCEL_START: accel_start_q <= cfg_data[7:0];
				REG_ACCEL_STEP:  accel_step_q  <= cfg_data[5:0];
				REG_ACCEL_CAP:   accel_cap_q   <= cfg_data[7:0];
				REG_GAIN:        gain_q        <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			head_slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rotate) begin
				head_slot_q <= head_next;
			end
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_xfer) begin
						// a tick reports a zero position when the table is empty
						probe_q.left <= s_axis_tuser ? spawn_x : '0;
						probe_q.top  <= s_axis_tuser ? spawn_y : '0;
						res_slot_q   <= '0;
						turn_q       <= '0;
						hit_q        <= 1'b0;
						hit_slot_q   <= '0;
						box_idx_q    <= '0;
						rep_q        <= 1'b0;
						if (s_axis_tuser) begin
							if (count_q == FULL_CNT) begin
								res_status_q <= ST_FULL;
								state_q      <= EMIT;
							end else begin
								state_q <= SP_SCAN;
							end
						end else if (count_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= EMIT;
						end else begin
							state_q <= ALIGN;
						end
					end
				end
				SP_SCAN: begin
					hit_q      <= hit_now;
					hit_slot_q <= hit_slot_now;
					turn_q     <= turn_q + 1'b1;
					if (turn_q == LAST_SLOT) begin
						if (hit_now) begin
							res_status_q <= ST_BLOCKED;
							res_slot_q   <= 6'(hit_slot_now);
							state_q      <= EMIT;
						end else begin
							state_q <= SP_WRITE;
						end
					end
				end
				SP_WRITE: begin
					if (CW'(head_slot_q) == count_q) begin
						res_status_q <= ST_SPAWNED;
						res_slot_q   <= 6'(head_slot_q);
						count_q      <= count_q + 1'b1;
						state_q      <= EMIT;
					end
				end
				EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_x_q      <= probe_q.left;
						out_y_q      <= probe_q.top;
						out_last_q   <= 1'b1;
						state_q      <= IDLE;
					end
				end
				ALIGN: begin
					if (head_slot_q == '0) begin
						state_q <= rep_q ? REPORT : TK_CAPT;
					end
				end
				TK_CAPT: begin
					probe_q     <= head;
					stop_q      <= (head.top >= $signed({1'b0, floor_y_q}));
					accel_new_q <= (head.accel < accel_cap_q) ? accel_grow : head.accel;
					turn_q      <= SW'(1);
					state_q     <= (MAX_BOXES == 1) ? MUL1 : TK_SCAN;
				end
				TK_SCAN: begin
					if (head_live &&
						below(probe_q.left, probe_q.top, head.left, head.top, box_size_q)) begin
						stop_q <= 1'b1;
					end
					turn_q <= turn_q + 1'b1;
					if (turn_q == LAST_SLOT) begin
						state_q <= MUL1;
					end
				end
				MUL1: begin
					prod_q  <= 11'(gain_q) * 11'(accel_new_q);
					state_q <= MUL2;
				end
				MUL2: begin
					drop_q  <= quot_full[DIV100_SH +: 5];
					state_q <= UPD;
				end
				UPD: begin
					box_idx_q <= box_idx_q + 1'b1;
					if (CW'(box_idx_q) == count_q - 1'b1) begin
						rep_q   <= 1'b1;
						state_q <= ALIGN;
					end else begin
						state_q <= TK_CAPT;
					end
				end
				REPORT: begin
					if (out_free) begin
						out_status_q <= ST_POS;
						out_slot_q   <= 6'(head_slot_q);
						out_x_q      <= head.left;
						out_y_q      <= head.top;
						out_last_q   <= (CW'(head_slot_q) == count_q - 1'b1);
						if (CW'(head_slot_q) == count_q - 1'b1) begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0, out_y_q, out_x_q, out_slot_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("box count beyond table size");

	a_report_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_POS) |-> (CW'(out_slot_q) < count_q))
		else $error("position report for an empty slot");

	a_count_spawn: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (state_q == EMIT && res_status_q == ST_SPAWNED))
		else $error("box count changed without a spawn");

endmodule

[dv/falling_box_stack_step_test.sv]
// Self-checking testbench of the falling box stack: predicted results against the stream output.
`timescale 1ns / 100ps

module falling_box_stack_step_test;
	import fbs_pkg::*;

	localparam int NBOX = 16;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         slot;
		logic signed [10:0] bx;
		logic signed [10:0] by;
		logic               last;
	} box_report_t;

	// Scoreboard: predicts the box table and checks each output transfer
	class stack_scoreboard;
		int floor_y = 500, size = 100, a_start = 10, a_step = 4, a_cap = 200, gain = 2;
		int left[NBOX], top[NBOX], accel[NBOX];
		int count = 0;
		box_report_t pending[$];
		int mismatches = 0, checked = 0;

		function void set_reg(logic [2:0] idx, int v);
			case (idx)
				REG_FLOOR_Y:     floor_y = v & 10'h3ff;
				REG_BOX_SIZE:    size = v & 8'hff;
				REG_ACCEL_START: a_start = v & 8'hff;
				REG_ACCEL_STEP:  a_step = v & 6'h3f;
				REG_ACCEL_CAP:   a_cap = v & 8'hff;
				REG_GAIN:        gain = v & 3'h7;
				default: ;
			endcase
		endfunction

		function bit touching(int ax, int ay, int bx, int by);
			int dx, dy;
			dx = ax - bx;
			dy = ay - by;
			return (dx < 0 ? -dx : dx) <= size && (dy < 0 ? -dy : dy) <= size;
		endfunction

		function bit resting_on(int ax, int ay, int bx, int by);
			int wy, hx;
			if (!touching(ax, ay, bx, by)) return 0;
			wy = size * (ay - by);
			hx = size * (ax - bx);
			return wy <= hx && wy <= -hx;
		endfunction

		function void push(logic [2:0] st, int sl, int x, int y, bit l);
			box_report_t r;
			r.status = st; r.slot = sl[5:0]; r.bx = x[10:0]; r.by = y[10:0]; r.last = l;
			pending.insert(pending.size(), r);
		endfunction

		// Note an accepted input transfer and queue what it should produce
		function void note_item(bit spawn, int cx, int cy);
			int x, y, ny;
			bit stop;
			if (spawn) begin
				x = cx - size / 2;
				y = cy - size / 2;
				if (count >= NBOX) begin
					push(ST_FULL, 0, x, y, 1);
					return;
				end
				for (int i = 0; i < count; i++)
					if (touching(left[i], top[i], x, y)) begin
						push(ST_BLOCKED, i, x, y, 1);
						return;
					end
				left[count] = x; top[count] = y; accel[count] = a_start;
				push(ST_SPAWNED, count, x, y, 1);
				count++;
				return;
			end
			if (count == 0) begin
				push(ST_EMPTY, 0, 0, 0, 1);
				return;
			end
			for (int i = 0; i < count; i++) begin
				stop = top[i] >= floor_y;
				for (int j = 0; j < count && !stop; j++)
					if (j != i && resting_on(left[i], top[i], left[j], top[j])) stop = 1;
				if (!stop) begin
					if (accel[i] < a_cap) accel[i] = (accel[i] + a_step > 255) ? 255
						: accel[i] + a_step;
					ny = top[i] + (gain * accel[i]) / 100;
					top[i] = ny > 1023 ? 1023 : ny;
				end
			end
			for (int i = 0; i < count; i++) push(ST_POS, i, left[i], top[i], i + 1 == count);
		endfunction

		function void check_result(box_report_t got);
			box_report_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status %0d slot %0d",
					got.status, got.slot);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want st%0d sl%0d x%0d y%0d l%0d, %s",
						want.status, want.slot, want.bx, want.by, want.last,
						$sformatf("got st%0d sl%0d x%0d y%0d l%0d",
						got.status, got.slot, got.bx, got.by, got.last));
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // [9:0] cursor_x, [19:10] cursor_y
	logic        s_axis_tuser = 0;   // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;       // [5:0] slot, [16:6] box_x, [27:17] box_y
	logic [2:0]  m_axis_tuser;       // [2:0] status
	logic        m_axis_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;

	stack_scoreboard board;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int items_sent = 0;

	falling_box_stack_step u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver: randomise tready on the falling edge, check transfers on the rising edge
	always @(posedge clk) begin
		box_report_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.status = m_axis_tuser;
			r.slot = m_axis_tdata[5:0];
			r.bx = m_axis_tdata[16:6];
			r.by = m_axis_tdata[27:17];
			r.last = m_axis_tlast;
			board.check_result(r);
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Hold each item until the transfer; idle between items as the phase asks
	task automatic send_item(bit spawn, int cx, int cy);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tuser = spawn;
		s_axis_tdata = {4'b0, cy[9:0], cx[9:0]};
		do @(posedge clk); while (!s_axis_tready);
		board.note_item(spawn, cx, cy);
		items_sent++;
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic write_reg(logic [2:0] idx, int v);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v[9:0];
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, v);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Wait for every expected result, then allow the ring a full turn to settle
	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (4 * NBOX + 8) @(negedge clk);
	endtask

	// Random content, mostly spawns near the stack so boxes collide and rest
	task automatic random_burst(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 45) send_item(0, $urandom, $urandom);
			else if ($urandom_range(3) == 0) send_item(1, $urandom_range(1023), $urandom_range(1023));
			else send_item(1, $urandom_range(300, 700), $urandom_range(0, 400));
		end
	endtask

	initial begin
		board = new();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty tick, extremes of cursor, blocked spawns, ticks on a partly filled table
		send_item(0, 0, 0);
		send_item(1, 0, 0);
		send_item(1, 1023, 1023);
		send_item(1, 0, 0);
		send_item(1, 500, 100);
		send_item(0, 1023, 1023);
		send_item(0, 0, 0);
		for (int i = 0; i < 14; i++) send_item(1, 60 + 70 * (i % 14), 5 + 150 * (i / 7));
		send_item(1, 900, 900);
		send_item(0, 0, 0);
		drain();

		// Zero size, top speed, lowest floor: overflow saturations
		write_reg(REG_BOX_SIZE, 0);
		write_reg(REG_GAIN, 7);
		write_reg(REG_ACCEL_START, 255);
		write_reg(REG_ACCEL_STEP, 63);
		write_reg(REG_ACCEL_CAP, 255);
		write_reg(REG_FLOOR_Y, 1023);
		write_reg(3'd7, 55);
		send_item(1, 10, 10);
		for (int i = 0; i < 6; i++) send_item(0, 0, 0);
		drain();

		// Random phases over several register settings
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_FLOOR_Y, ph == 0 ? 0 : $urandom_range(200, 1023));
			write_reg(REG_BOX_SIZE, ph == 1 ? 255 : $urandom_range(1, 120));
			write_reg(REG_ACCEL_START, $urandom_range(255));
			write_reg(REG_ACCEL_STEP, ph == 2 ? 0 : $urandom_range(63));
			write_reg(REG_ACCEL_CAP, ph == 3 ? 0 : $urandom_range(255));
			write_reg(REG_GAIN, $urandom_range(7));
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			random_burst(26);
			drain();
		end

		$display("Covered %0d items and %0d results: empty, spawn, blocked, full and tick paths,",
			items_sent, board.checked);
		$display("register extremes and four idle/stall patterns.");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
